// ===== rtl/srs_pkg.sv =====
// Shared constants and types for the semivariance ratio stream unit.
`timescale 1ns / 1ps
`default_nettype none
package srs_pkg;
   localparam int PRICE_BITS      = 32;
   localparam int LOG_TABLE_BITS  = 10;
   localparam int RATIO_FRAC_BITS = 16;
   localparam int LOG_W           = 33;
   localparam int LOG_FRAC_W      = 28;
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

   typedef struct packed {
      logic             usable;
      logic             last;
      logic [LOG_W-1:0] logv;
   } srs_entry_type;
endpackage
`default_nettype wire

// ===== rtl/srs_queue.sv =====
// Two-entry queue that carries classified samples from the front end to the back end.
`timescale 1ns / 1ps
`default_nettype none
module srs_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire srs_pkg::srs_entry_type push_data,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       empty,
   output srs_pkg::srs_entry_type      pop_data
);
   srs_pkg::srs_entry_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/srs_front.sv =====
// Front end: accepts price samples, classifies them and computes their base-2 logarithm.
`timescale 1ns / 1ps
`default_nettype none
module srs_front #(
   parameter int PRICE_BITS     = srs_pkg::PRICE_BITS,
   parameter int LOG_TABLE_BITS = srs_pkg::LOG_TABLE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [31:0]            req_price,
   input  wire logic                   req_price_missing,
   input  wire logic                   req_last_of_series,
   output logic                        push_valid,
   output srs_pkg::srs_entry_type       push_data,
   input  wire logic                   queue_full
);
   localparam int REST_W    = 31 - LOG_TABLE_BITS;
   localparam int ROM_SHIFT = 30 - LOG_TABLE_BITS;
   localparam logic [31:0] PRICE_MASK = 32'hFFFF_FFFF >> (32 - PRICE_BITS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_NORM   = 3'd1;
   localparam logic [2:0] ST_ROM_A  = 3'd2;
   localparam logic [2:0] ST_ROM_B  = 3'd3;
   localparam logic [2:0] ST_INTERP = 3'd4;
   localparam logic [2:0] ST_PUSH   = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [31:0]               norm_ff, norm_in;
   logic [4:0]                exp_ff, exp_in;
   logic                      usable_ff, usable_in;
   logic                      last_ff, last_in;
   logic [LOG_TABLE_BITS:0]   idx_ff, idx_in;
   logic [30:0]               y_ff, y_in;
   logic [27:0]               acc_ff, acc_in;
   logic [4:0]                step_ff, step_in;
   logic [28:0]               rom_a_ff, rom_a_in;
   logic [28:0]               rom_b_ff, rom_b_in;
   logic [srs_pkg::LOG_W-1:0] log_ff, log_in;

   logic [31:0]               price_masked;
   logic [61:0]               square;
   logic [31:0]               y_sq;
   logic [27:0]               acc_next;
   logic [30:0]               y_next;
   logic [LOG_TABLE_BITS:0]   idx_plus;
   logic [28:0]               rom_diff;
   logic [28+REST_W:0]        interp_prod;
   logic [28:0]               interp_val;

   assign price_masked = req_price & PRICE_MASK;
   assign square       = {31'd0, y_ff} * {31'd0, y_ff};
   assign y_sq         = square[61:30];
   assign acc_next     = {acc_ff[26:0], y_sq[31]};
   assign y_next       = y_sq[31] ? y_sq[31:1] : y_sq[30:0];
   assign idx_plus     = idx_ff + {{LOG_TABLE_BITS{1'b0}}, 1'b1};
   assign rom_diff     = rom_b_ff - rom_a_ff;
   assign interp_prod  = {{REST_W{1'b0}}, rom_diff} * {29'd0, norm_ff[REST_W-1:0]};
   assign interp_val   = rom_a_ff + interp_prod[28+REST_W:REST_W];

   assign req_stall  = (state_ff != ST_IDLE);
   assign push_valid = (state_ff == ST_PUSH);
   assign push_data  = '{usable: usable_ff, last: last_ff, logv: log_ff};

   always_comb begin
      state_in  = state_ff;
      norm_in   = norm_ff;
      exp_in    = exp_ff;
      usable_in = usable_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      rom_a_in  = rom_a_ff;
      rom_b_in  = rom_b_ff;
      log_in    = log_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               usable_in = !req_price_missing && (price_masked != 32'd0);
               last_in   = req_last_of_series;
               norm_in   = price_masked;
               exp_in    = 5'd31;
               state_in  = usable_in ? ST_NORM : ST_PUSH;
            end
         end
         ST_NORM: begin
            if (norm_ff[31]) begin
               idx_in   = {1'b0, norm_ff[30 -: LOG_TABLE_BITS]};
               y_in     = {1'b1, norm_ff[30 -: LOG_TABLE_BITS], {ROM_SHIFT{1'b0}}};
               acc_in   = '0;
               step_in  = '0;
               state_in = ST_ROM_A;
            end else begin
               norm_in = {norm_ff[30:0], 1'b0};
               exp_in  = exp_ff - 5'd1;
            end
         end
         ST_ROM_A: begin
            y_in    = y_next;
            acc_in  = acc_next;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd27) begin
               rom_a_in = {1'b0, acc_next};
               step_in  = '0;
               acc_in   = '0;
               if (idx_plus[LOG_TABLE_BITS]) begin
                  rom_b_in = srs_pkg::ONE_Q28;
                  state_in = ST_INTERP;
               end else begin
                  y_in     = {1'b1, idx_plus[LOG_TABLE_BITS-1:0], {ROM_SHIFT{1'b0}}};
                  state_in = ST_ROM_B;
               end
            end
         end
         ST_ROM_B: begin
            y_in    = y_next;
            acc_in  = acc_next;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd27) begin
               rom_b_in = {1'b0, acc_next};
               state_in = ST_INTERP;
            end
         end
         ST_INTERP: begin
            log_in   = {exp_ff, 28'd0} + {4'd0, interp_val};
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!queue_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      norm_ff   <= norm_in;
      exp_ff    <= exp_in;
      usable_ff <= usable_in;
      last_ff   <= last_in;
      idx_ff    <= idx_in;
      y_ff      <= y_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
      rom_a_ff  <= rom_a_in;
      rom_b_ff  <= rom_b_in;
      log_ff    <= log_in;
   end
endmodule
`default_nettype wire

// ===== rtl/srs_back.sv =====
// Back end: squares log returns, accumulates semivariances and divides at series end unless there is no downside.
`timescale 1ns / 1ps
`default_nettype none
module srs_back #(
   parameter int RATIO_FRAC_BITS = srs_pkg::RATIO_FRAC_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   queue_empty,
   input  wire srs_pkg::srs_entry_type  pop_data,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [31:0]                 rsp_ratio,
   output logic                        rsp_no_downside,
   output logic                        rsp_saturated
);
   localparam int DIVD_W = 64 + RATIO_FRAC_BITS;
   localparam int CNT_W  = $clog2(DIVD_W + 1);
   localparam logic [CNT_W-1:0] HIGH_STEPS = CNT_W'(DIVD_W - 32);
   localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(DIVD_W - 1);

   localparam logic [3:0] B_IDLE = 4'd0;
   localparam logic [3:0] B_DIFF = 4'd1;
   localparam logic [3:0] B_LN   = 4'd2;
   localparam logic [3:0] B_SQ   = 4'd3;
   localparam logic [3:0] B_ACC  = 4'd4;
   localparam logic [3:0] B_POST = 4'd5;
   localparam logic [3:0] B_DIV  = 4'd6;
   localparam logic [3:0] B_EMIT = 4'd7;

   logic [3:0]                state_ff, state_in;
   srs_pkg::srs_entry_type    cur_ff, cur_in;
   logic                      prev_usable_ff, prev_usable_in;
   logic [srs_pkg::LOG_W-1:0] prev_log_ff, prev_log_in;
   logic                      pos_ff, pos_in;
   logic [srs_pkg::LOG_W-1:0] diff_ff, diff_in;
   logic [30:0]               mag_ff, mag_in;
   logic [61:0]               sq_ff, sq_in;
   logic [63:0]               up_ff, up_in;
   logic [63:0]               down_ff, down_in;
   logic                      sat_ff, sat_in;
   logic [64:0]               rem_ff, rem_in;
   logic [DIVD_W-1:0]         dvd_ff, dvd_in;
   logic [31:0]               quot_ff, quot_in;
   logic                      ovf_ff, ovf_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [31:0]               res_ratio_ff, res_ratio_in;
   logic                      res_nd_ff, res_nd_in;
   logic                      res_sat_ff, res_sat_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_ratio_ff;
   logic                      rsp_nd_ff;
   logic                      rsp_sat_ff;

   logic [63:0] ln_prod;
   logic [63:0] ln_round;
   logic [64:0] acc_sum;
   logic [64:0] shifted;
   logic        div_ge;
   logic        ovf_next;
   logic [31:0] quot_next;
   logic        load_out;

   assign ln_prod   = {31'd0, diff_ff} * {34'd0, srs_pkg::LN2_Q30};
   assign ln_round  = ln_prod + 64'h2000_0000;
   assign acc_sum   = {1'b0, (pos_ff ? up_ff : down_ff)} + {3'd0, sq_ff};
   assign shifted   = {rem_ff[63:0], dvd_ff[DIVD_W-1]};
   assign div_ge    = shifted >= {1'b0, down_ff};
   assign ovf_next  = ovf_ff || (div_ge && (cnt_ff < HIGH_STEPS));
   assign quot_next = {quot_ff[30:0], div_ge};
   assign load_out  = (state_ff == B_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign pop       = (state_ff == B_IDLE) && !queue_empty;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ratio       = rsp_ratio_ff;
   assign rsp_no_downside = rsp_nd_ff;
   assign rsp_saturated   = rsp_sat_ff;
   assign rsp_valid_in    = (rsp_valid_ff && rsp_stall) || load_out;

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      prev_usable_in = prev_usable_ff;
      prev_log_in    = prev_log_ff;
      pos_in         = pos_ff;
      diff_in        = diff_ff;
      mag_in         = mag_ff;
      sq_in          = sq_ff;
      up_in          = up_ff;
      down_in        = down_ff;
      sat_in         = sat_ff;
      rem_in         = rem_ff;
      dvd_in         = dvd_ff;
      quot_in        = quot_ff;
      ovf_in         = ovf_ff;
      cnt_in         = cnt_ff;
      res_ratio_in   = res_ratio_ff;
      res_nd_in      = res_nd_ff;
      res_sat_in     = res_sat_ff;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               cur_in   = pop_data;
               state_in = B_DIFF;
            end
         end
         B_DIFF: begin
            if (cur_ff.usable && prev_usable_ff) begin
               pos_in   = cur_ff.logv > prev_log_ff;
               diff_in  = pos_in ? cur_ff.logv - prev_log_ff : prev_log_ff - cur_ff.logv;
               state_in = B_LN;
            end else begin
               state_in = B_POST;
            end
         end
         B_LN: begin
            mag_in   = (ln_round[63:30] > 34'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : ln_round[60:30];
            state_in = B_SQ;
         end
         B_SQ: begin
            sq_in    = {31'd0, mag_ff} * {31'd0, mag_ff};
            state_in = B_ACC;
         end
         B_ACC: begin
            if (pos_ff) begin
               up_in = acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
            end else begin
               down_in = acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
            end
            sat_in   = sat_ff || acc_sum[64];
            state_in = B_POST;
         end
         B_POST: begin
            prev_usable_in = cur_ff.usable;
            prev_log_in    = cur_ff.logv;
            if (!cur_ff.last) begin
               state_in = B_IDLE;
            end else if (down_ff == 64'd0) begin
               res_ratio_in = 32'd0;
               res_nd_in    = 1'b1;
               res_sat_in   = sat_ff;
               state_in     = B_EMIT;
            end else begin
               rem_in   = '0;
               dvd_in   = {up_ff, {RATIO_FRAC_BITS{1'b0}}};
               quot_in  = '0;
               ovf_in   = 1'b0;
               cnt_in   = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            rem_in  = div_ge ? shifted - {1'b0, down_ff} : shifted;
            dvd_in  = {dvd_ff[DIVD_W-2:0], 1'b0};
            quot_in = quot_next;
            ovf_in  = ovf_next;
            cnt_in  = cnt_ff + {{(CNT_W-1){1'b0}}, 1'b1};
            if (cnt_ff == LAST_STEP) begin
               res_ratio_in = ovf_next ? 32'hFFFF_FFFF : quot_next;
               res_nd_in    = 1'b0;
               res_sat_in   = sat_ff || ovf_next;
               state_in     = B_EMIT;
            end
         end
         B_EMIT: begin
            if (load_out) begin
               up_in          = '0;
               down_in        = '0;
               sat_in         = 1'b0;
               prev_usable_in = 1'b0;
               state_in       = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_IDLE;
         prev_usable_ff <= 1'b0;
         up_ff          <= '0;
         down_ff        <= '0;
         sat_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         prev_usable_ff <= prev_usable_in;
         up_ff          <= up_in;
         down_ff        <= down_in;
         sat_ff         <= sat_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      prev_log_ff  <= prev_log_in;
      pos_ff       <= pos_in;
      diff_ff      <= diff_in;
      mag_ff       <= mag_in;
      sq_ff        <= sq_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      quot_ff      <= quot_in;
      ovf_ff       <= ovf_in;
      cnt_ff       <= cnt_in;
      res_ratio_ff <= res_ratio_in;
      res_nd_ff    <= res_nd_in;
      res_sat_ff   <= res_sat_in;
      if (load_out) begin
         rsp_ratio_ff <= res_ratio_ff;
         rsp_nd_ff    <= res_nd_ff;
         rsp_sat_ff   <= res_sat_ff;
      end
   end

`ifndef SYNTHESIS
   a_cleared_after_result: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (up_ff == 64'd0 && down_ff == 64'd0 && !sat_ff && !prev_usable_ff))
      else $error("Series state was not cleared after a result.");
   a_no_downside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_nd_ff) |-> (rsp_ratio_ff == 32'd0))
      else $error("Ratio is nonzero on a result without downside.");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (cnt_ff <= LAST_STEP))
      else $error("Division step count overran.");
`endif
endmodule
`default_nettype wire

// ===== rtl/semivariance_ratio_stream_unit.sv =====
// Semivariance ratio stream unit: top level joining front end, queue and back end.
// A usable sample passes the front end as acceptance, normalize shifts, a leading-one check, one or
// two 28-step squaring runs, interpolation and a push; a missing or zero sample goes straight to push.
// The back end pops, differences, and for a usable pair scales to ln, squares and accumulates.
// At the series end, unless downside is zero, a restoring divider forms the ratio bit by bit.
// Synchronous active-high reset clears all series state; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module semivariance_ratio_stream_unit #(
   parameter int PRICE_BITS      = srs_pkg::PRICE_BITS,
   parameter int LOG_TABLE_BITS  = srs_pkg::LOG_TABLE_BITS,
   parameter int RATIO_FRAC_BITS = srs_pkg::RATIO_FRAC_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_price,
   input  wire logic        req_price_missing,
   input  wire logic        req_last_of_series,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_ratio,
   output logic             rsp_no_downside,
   output logic             rsp_saturated
);
   logic                   push_valid;
   srs_pkg::srs_entry_type push_data;
   logic                   queue_full;
   logic                   queue_empty;
   logic                   pop;
   srs_pkg::srs_entry_type pop_data;

   srs_front #(
      .PRICE_BITS     (PRICE_BITS),
      .LOG_TABLE_BITS (LOG_TABLE_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_price          (req_price),
      .req_price_missing  (req_price_missing),
      .req_last_of_series (req_last_of_series),
      .push_valid         (push_valid),
      .push_data          (push_data),
      .queue_full         (queue_full)
   );

   srs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .pop_data   (pop_data)
   );

   srs_back #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ratio       (rsp_ratio),
      .rsp_no_downside (rsp_no_downside),
      .rsp_saturated   (rsp_saturated)
   );
endmodule
`default_nettype wire
